/* rtl/fdp_pkg.sv */
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared types and constants of the fixed-width decimal text parser.
// ----------------------------------------------------------------------------
package fdp_pkg;

    localparam int CHAR_BITS = 8;
    localparam int CFG_ADDR_BITS = 8;
    localparam int CFG_DATA_BITS = 8;
    localparam int POS_BITS = 8;

    // Register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FIELD_LENGTH   = 8'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DECIMAL_PLACES = 8'd1;

    localparam logic [CFG_DATA_BITS-1:0] FIELD_LENGTH_RST   = 8'd5;
    localparam logic [CFG_DATA_BITS-1:0] DECIMAL_PLACES_RST = 8'd0;

    localparam logic [CHAR_BITS-1:0] DIGIT_BASE = 8'h30;
    localparam logic [CHAR_BITS-1:0] POINT_CHAR = 8'h2E;
    localparam logic [CHAR_BITS-1:0] MAX_DIGIT  = 8'd9;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] field_length;
        logic [CFG_DATA_BITS-1:0] decimal_places;
    } t_cfg;

endpackage

/* rtl/fdp_if.sv */
// ----------------------------------------------------------------------------
// fdp_if
// Valid/ready channels of the parser: characters, results, register writes.
// ----------------------------------------------------------------------------
interface fdp_char_if;
    logic                           valid;
    logic                           ready;
    logic [fdp_pkg::CHAR_BITS-1:0]  character;
    logic                           first;

    modport source (output valid, output character, output first, input ready);
    modport sink   (input valid, input character, input first, output ready);
endinterface

interface fdp_result_if #(
    parameter int VALUE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_BITS-1:0]  value;
    logic                   ok;

    modport source (output valid, output value, output ok, input ready);
    modport sink   (input valid, input value, input ok, output ready);
endinterface

interface fdp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fdp_pkg::CFG_ADDR_BITS-1:0]  addr;
    logic [fdp_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

/* rtl/fdp_cfg.sv */
// ----------------------------------------------------------------------------
// fdp_cfg
// Configuration registers: field length and decimal places.
// ----------------------------------------------------------------------------
module fdp_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fdp_cfg_if.sink         i_cfg,
    output fdp_pkg::t_cfg   o_cfg
);

    fdp_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_length   <= fdp_pkg::FIELD_LENGTH_RST;
            r_cfg.decimal_places <= fdp_pkg::DECIMAL_PLACES_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                fdp_pkg::CFG_FIELD_LENGTH:   r_cfg.field_length   <= i_cfg.data;
                fdp_pkg::CFG_DECIMAL_PLACES: r_cfg.decimal_places <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/fdp_step.sv */
// ----------------------------------------------------------------------------
// fdp_step
// Per-character field state, digit accumulate and the result register.
// ----------------------------------------------------------------------------
module fdp_step #(
    parameter int VALUE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fdp_pkg::t_cfg                   i_cfg,
    input  logic                            i_valid,
    input  logic [fdp_pkg::CHAR_BITS-1:0]   i_character,
    input  logic                            i_first,
    output logic                            o_ready,
    output logic                            o_valid,
    input  logic                            i_out_ready,
    output logic [VALUE_BITS-1:0]           o_value,
    output logic                            o_ok
);

    localparam int LEN_BITS = fdp_pkg::POS_BITS + 1;

    logic [fdp_pkg::POS_BITS-1:0]   r_pos,  n_pos;
    logic [VALUE_BITS-1:0]          r_acc,  n_acc;
    logic                           r_bad,  n_bad;
    logic                           r_out_valid;
    logic [VALUE_BITS-1:0]          r_value;
    logic                           r_ok;

    logic [LEN_BITS-1:0]            w_len;
    logic [LEN_BITS-1:0]            w_dp;
    logic [fdp_pkg::POS_BITS-1:0]   w_pos;
    logic [VALUE_BITS-1:0]          w_acc_prev;
    logic                           w_bad_prev;
    logic [fdp_pkg::CHAR_BITS-1:0]  w_digit;
    logic                           w_point;
    logic                           w_char_bad;
    logic                           w_last;
    logic                           w_take;

    // Length zero stands for 256
    assign w_len = {(i_cfg.field_length == '0), i_cfg.field_length};
    assign w_dp  = {1'b0, i_cfg.decimal_places};

    assign w_pos      = i_first ? '0 : r_pos;
    assign w_acc_prev = i_first ? '0 : r_acc;
    assign w_bad_prev = i_first ? 1'b0 : r_bad;

    assign w_point = (w_dp != '0) && (w_dp < w_len)
                   && ({1'b0, w_pos} == (w_len - w_dp - LEN_BITS'(1)));

    assign w_digit    = i_character - fdp_pkg::DIGIT_BASE;
    assign w_char_bad = w_point ? (i_character != fdp_pkg::POINT_CHAR)
                                : (w_digit > fdp_pkg::MAX_DIGIT);
    assign w_last     = ({1'b0, w_pos} + LEN_BITS'(1)) == w_len;

    // Only the last character needs room in the result register
    assign o_ready = !w_last || !r_out_valid || i_out_ready;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_bad = w_bad_prev | w_char_bad;
        n_acc = w_acc_prev;
        if (!w_point && !w_char_bad && !w_bad_prev) begin
            n_acc = (w_acc_prev << 3) + (w_acc_prev << 1) + VALUE_BITS'(w_digit);
        end
        n_pos = w_pos + fdp_pkg::POS_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_acc       <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                if (w_last) begin
                    r_pos <= '0;
                    r_acc <= '0;
                    r_bad <= 1'b0;
                end else begin
                    r_pos <= n_pos;
                    r_acc <= n_acc;
                    r_bad <= n_bad;
                end
            end
            if (w_take && w_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_last) begin
            r_value <= n_bad ? '0 : n_acc;
            r_ok    <= !n_bad;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;
    assign o_ok    = r_ok;

`ifndef ASSERT_OFF
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_take && w_last))
        else $error("result appeared without a last character");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && w_last && r_out_valid && !i_out_ready) |-> !w_take)
        else $error("pending result would be overwritten");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_last) |=> (r_pos == $past(n_pos)))
        else $error("position did not advance");

    a_field_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_last) |=> (r_pos == '0 && r_acc == '0 && !r_bad))
        else $error("field state not cleared after last character");
`endif

endmodule

/* rtl/fixed_point_decimal_text_parser.sv */
// ----------------------------------------------------------------------------
// fixed_point_decimal_text_parser
// ASCII fixed-width decimal field to binary, with optional decimal point.
// ----------------------------------------------------------------------------
// One character item is taken every clock cycle. A character passes an input
// register, then one short stage (decode, point check, multiply by ten and
// add) updates the field state; the result of a field is loaded into the
// output register as its last character is taken. Intake pauses only when a
// last character finds the output register still holding an untaken result.
// The user must write registers through the configuration channel only while
// no field is in flight; the block itself does not enforce this.
module fixed_point_decimal_text_parser #(
    parameter int VALUE_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fdp_char_if.sink        i_char,
    fdp_result_if.source    o_result,
    fdp_cfg_if.sink         i_cfg
);

    fdp_pkg::t_cfg                  w_cfg;
    logic                           r_in_valid;
    logic [fdp_pkg::CHAR_BITS-1:0]  r_in_char;
    logic                           r_in_first;
    logic                           w_step_ready;
    logic                           w_in_ready;

    assign w_in_ready   = !r_in_valid || w_step_ready;
    assign i_char.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_char.valid) begin
            r_in_char  <= i_char.character;
            r_in_first <= i_char.first;
        end
    end

    fdp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    fdp_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (r_in_valid),
        .i_character (r_in_char),
        .i_first     (r_in_first),
        .o_ready     (w_step_ready),
        .o_valid     (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_value     (o_result.value),
        .o_ok        (o_result.ok)
    );

endmodule
